### rtl/tss_pkg.sv
// shared constants, types and helpers of the tone script sequencer
package tss_pkg;

	localparam int SCRIPT_DEPTH = 256;
	localparam int MAX_EVENTS = 8;
	localparam int ADDR_W = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);

	localparam logic [7:0] EV_STOP = 8'h80;
	localparam logic [7:0] EV_END = 8'hFF;
	localparam logic [1:0] PRESCALE_MASK = 2'h3;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_RESTART = 2'd1,
		OP_LOAD = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_PLAY = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CODE,
		ST_OCT,
		ST_LEN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_t command;
		logic [7:0] semitone;
		logic [7:0] octave;
		logic is_playing;
		logic last;
	} result_t;

	typedef struct packed {
		logic load;
		result_t res;
	} emit_t;

	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
		logic [ADDR_W-1:0] nxt;
		if (ptr == ADDR_W'(SCRIPT_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + ADDR_W'(1);
		end
		return nxt;
	endfunction

endpackage

### rtl/tss_script_ram.sv
// script memory, one write port and one registered read port
module tss_script_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [tss_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic [tss_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                 rd_data
);

	logic [7:0] mem [tss_pkg::SCRIPT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/tss_out_stage.sv
// output register holding one result until the receiver takes it
module tss_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  tss_pkg::emit_t   emit,
	output logic             free,
	output logic             valid,
	input  logic             ready,
	output tss_pkg::result_t res
);

	logic valid_q;
	tss_pkg::result_t res_q;

	assign free = !valid_q || ready;
	assign valid = valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= emit.load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && emit.load) begin
			res_q <= emit.res;
		end
	end

endmodule

### rtl/tss_interp.sv
// script interpreter: prescaler, timing registers and event sequencing
module tss_interp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tss_pkg::op_t               op,
	input  logic [7:0]                 load_address,
	input  logic [7:0]                 load_byte,
	output logic                       wr_en,
	output logic [tss_pkg::ADDR_W-1:0] wr_addr,
	output logic [7:0]                 wr_data,
	output logic [tss_pkg::ADDR_W-1:0] rd_addr,
	input  logic [7:0]                 rd_data,
	input  logic                       out_free,
	output tss_pkg::emit_t             emit
);

	tss_pkg::state_t state_q, state_d;

	logic [tss_pkg::ADDR_W-1:0] ptr_q;
	logic [15:0]                tick_q;
	logic [7:0]                 wait_q;
	logic                       running_q;
	logic [1:0]                 prescale_q;
	logic [tss_pkg::CNT_W-1:0]  n_q;
	logic [7:0]                 code_q;
	logic [7:0]                 oct_q;
	tss_pkg::result_t           res_q;

	logic                      fire;
	logic                      due;
	logic                      start_run;
	logic [tss_pkg::CNT_W-1:0] n_inc;
	logic                      cont;
	logic                      code_stop;

	always_comb begin
		fire = (prescale_q & tss_pkg::PRESCALE_MASK) == 2'd0;
		due = tick_q >= 16'(wait_q);
		start_run = (op == tss_pkg::OP_TICK) && fire && running_q && due;
		n_inc = n_q + tss_pkg::CNT_W'(1);
		cont = (rd_data == 8'h00) && (32'(n_inc) < tss_pkg::MAX_EVENTS);
		code_stop = code_q == tss_pkg::EV_STOP;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = start_run ? tss_pkg::ST_CODE : tss_pkg::ST_EMIT;
				end
			end
			tss_pkg::ST_CODE: begin
				if (rd_data == tss_pkg::EV_END) begin
					state_d = tss_pkg::ST_EMIT;
				end else if (rd_data == tss_pkg::EV_STOP) begin
					state_d = tss_pkg::ST_LEN;
				end else begin
					state_d = tss_pkg::ST_OCT;
				end
			end
			tss_pkg::ST_OCT: begin
				state_d = tss_pkg::ST_LEN;
			end
			tss_pkg::ST_LEN: begin
				state_d = tss_pkg::ST_EMIT;
			end
			tss_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = res_q.last ? tss_pkg::ST_IDLE : tss_pkg::ST_CODE;
				end
			end
			default: begin
				state_d = tss_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		rd_addr = ptr_q;
		wr_en = 1'b0;
		wr_addr = tss_pkg::ADDR_W'(load_address);
		wr_data = load_byte;
		emit.load = 1'b0;
		emit.res = res_q;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				wr_en = in_valid && (op == tss_pkg::OP_LOAD)
					&& (32'(load_address) < tss_pkg::SCRIPT_DEPTH);
			end
			tss_pkg::ST_CODE, tss_pkg::ST_OCT: begin
				rd_addr = tss_pkg::ptr_inc(ptr_q);
			end
			tss_pkg::ST_LEN: begin
				rd_addr = ptr_q;
			end
			tss_pkg::ST_EMIT: begin
				emit.load = out_free;
			end
			default: begin
				rd_addr = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::ST_IDLE;
			ptr_q <= '0;
			tick_q <= '0;
			wait_q <= '0;
			running_q <= 1'b0;
			prescale_q <= '0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tss_pkg::ST_IDLE: begin
					if (in_valid) begin
						unique case (op)
							tss_pkg::OP_TICK: begin
								prescale_q <= (prescale_q + 2'd1) & tss_pkg::PRESCALE_MASK;
								if (fire) begin
									tick_q <= tick_q + 16'd1;
								end
								if (start_run) begin
									n_q <= '0;
								end
							end
							tss_pkg::OP_RESTART: begin
								ptr_q <= '0;
								tick_q <= '0;
								wait_q <= '0;
								running_q <= 1'b1;
							end
							tss_pkg::OP_LOAD, tss_pkg::OP_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				tss_pkg::ST_CODE: begin
					if (rd_data == tss_pkg::EV_END) begin
						running_q <= 1'b0;
					end else begin
						ptr_q <= tss_pkg::ptr_inc(ptr_q);
					end
				end
				tss_pkg::ST_OCT: begin
					ptr_q <= tss_pkg::ptr_inc(ptr_q);
				end
				tss_pkg::ST_LEN: begin
					wait_q <= rd_data;
					ptr_q <= tss_pkg::ptr_inc(ptr_q);
					tick_q <= 16'd1;
					n_q <= n_inc;
				end
				tss_pkg::ST_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				res_q.command <= tss_pkg::CMD_NONE;
				res_q.semitone <= '0;
				res_q.octave <= '0;
				res_q.is_playing <= (op == tss_pkg::OP_RESTART) ? 1'b1 : running_q;
				res_q.last <= 1'b1;
			end
			tss_pkg::ST_CODE: begin
				code_q <= rd_data;
				res_q.command <= tss_pkg::CMD_STOP;
				res_q.semitone <= '0;
				res_q.octave <= '0;
				res_q.is_playing <= 1'b0;
				res_q.last <= 1'b1;
			end
			tss_pkg::ST_OCT: begin
				oct_q <= rd_data;
			end
			tss_pkg::ST_LEN: begin
				res_q.command <= code_stop ? tss_pkg::CMD_STOP : tss_pkg::CMD_PLAY;
				res_q.semitone <= code_stop ? 8'h00 : code_q;
				res_q.octave <= code_stop ? 8'h00 : oct_q;
				res_q.is_playing <= running_q;
				res_q.last <= !cont;
			end
			tss_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/tone_script_sequencer.sv
// top level of the tone script sequencer
// usage:
//   requests enter on the s_axis channel: tuser carries the op (tick, restart,
//   load), tdata the load address and load byte. results leave on the m_axis
//   channel: tuser carries the command, tdata the semitone, octave and the
//   playing flag, tlast marks the final result of a request.
//   a load, a restart or a tick that plays nothing puts its one result on
//   m_axis by way of the emit state and then the output register. a tick
//   that plays events gives one result per event, each walking the script
//   memory one read a cycle: a stop passes the code and length states, a
//   tone the code, octave and length states and the end of the melody the
//   code state alone, each then the emit state and the output register; at
//   most eight events follow one tick.
//   the next request is taken the cycle after the last result of the previous
//   one enters the output register, so a request without events passes only
//   the idle and emit states; a stalled receiver holds that register and the
//   sequencer waits before handing over the next result.
//   reset clears the pointer, counters, prescaler and playing flag; the script
//   memory keeps whatever it held and must be loaded before a restart.
module tone_script_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // load_address, load_byte
	input  logic [1:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // semitone, octave, is_playing, zero pad
	output logic [1:0]  m_axis_tuser,  // command
	output logic        m_axis_tlast
);

	logic                       wr_en;
	logic [tss_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0]                 wr_data;
	logic [tss_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                 rd_data;
	logic                       out_free;
	tss_pkg::emit_t             emit;
	tss_pkg::result_t           res;

	tss_script_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tss_interp u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.op           (tss_pkg::op_t'(s_axis_tuser)),
		.load_address (s_axis_tdata[7:0]),
		.load_byte    (s_axis_tdata[15:8]),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_free     (out_free),
		.emit         (emit)
	);

	tss_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.emit   (emit),
		.free   (out_free),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.res    (res)
	);

	assign m_axis_tdata = {7'b0, res.is_playing, res.octave, res.semitone};
	assign m_axis_tuser = res.command;
	assign m_axis_tlast = res.last;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench of the tone script sequencer: directed table, random scripts, result scoreboard
module tb_top;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_REQS = 360;
	localparam int DRAIN_CYCLES = 16;
	localparam int N_DIRECTED = 23;

	typedef struct packed {
		tss_pkg::op_t op;
		logic [7:0] addr;
		logic [7:0] data;
		logic typed;
		tss_pkg::result_t want;
	} req_row_t;

	localparam tss_pkg::result_t IDLE_OFF = '{tss_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0, 1'b1};
	localparam tss_pkg::result_t IDLE_ON = '{tss_pkg::CMD_NONE, 8'h00, 8'h00, 1'b1, 1'b1};

	localparam req_row_t DIRECTED [N_DIRECTED] = '{
		'{tss_pkg::OP_LOAD, 8'h00, 8'h05, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'h01, 8'h04, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'h02, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'h03, 8'h80, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'h04, 8'h01, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'h05, 8'hFF, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'hFF, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_LOAD, 8'hFF, 8'hFF, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_NONE, 8'hFF, 8'hFF, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_RESTART, 8'h00, 8'h00, 1'b1, IDLE_ON},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_ON},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_ON},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_ON},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b1, IDLE_OFF},
		'{tss_pkg::OP_RESTART, 8'hFF, 8'hFF, 1'b1, IDLE_ON},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, IDLE_OFF},
		'{tss_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, IDLE_OFF}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // load_address, load_byte
	logic [1:0]  s_axis_tuser = '0;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // semitone, octave, is_playing, zero pad
	logic [1:0]  m_axis_tuser;  // command
	logic        m_axis_tlast;

	logic [7:0]                 script_img [tss_pkg::SCRIPT_DEPTH];
	logic [tss_pkg::ADDR_W-1:0] play_ptr = '0;
	logic [15:0]                fired_ticks = '0;
	logic [7:0]                 hold_len = '0;
	logic                       melody_on = 1'b0;
	logic [1:0]                 prescale = '0;

	tss_pkg::result_t expected_results [$];
	int               mismatches = 0;
	int               random_reqs = 0;
	int               stall_left = 0;
	logic             steady = 1'b0;
	int unsigned      cycle_count = 0;

	tone_script_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic predict_request(input tss_pkg::op_t op, input logic [7:0] addr,
			input logic [7:0] data, ref tss_pkg::result_t events[$]);
		tss_pkg::result_t ev;
		logic due;
		logic scan;
		logic [7:0] code;
		logic [tss_pkg::ADDR_W-1:0] nxt;
		events.delete();
		if (op == tss_pkg::OP_TICK) begin
			scan = (prescale == 2'd0);
			prescale = prescale + 2'd1;
			while (scan) begin
				due = (fired_ticks >= 16'(hold_len));
				fired_ticks = fired_ticks + 16'd1;
				if (!melody_on || !due || events.size() >= tss_pkg::MAX_EVENTS) begin
					scan = 1'b0;
				end else begin
					code = script_img[play_ptr];
					nxt = tss_pkg::ptr_inc(play_ptr);
					ev = IDLE_OFF;
					ev.last = 1'b0;
					if (code == tss_pkg::EV_END) begin
						// pointer stays on the end byte
						melody_on = 1'b0;
						ev.command = tss_pkg::CMD_STOP;
						scan = 1'b0;
					end else if (code == tss_pkg::EV_STOP) begin
						ev.command = tss_pkg::CMD_STOP;
						play_ptr = nxt;
					end else begin
						ev.command = tss_pkg::CMD_PLAY;
						ev.semitone = code;
						ev.octave = script_img[nxt];
						play_ptr = tss_pkg::ptr_inc(nxt);
					end
					ev.is_playing = melody_on;
					events.push_back(ev);
					if (scan) begin
						hold_len = script_img[play_ptr];
						play_ptr = tss_pkg::ptr_inc(play_ptr);
						fired_ticks = '0;
					end
				end
			end
		end else if (op == tss_pkg::OP_RESTART) begin
			play_ptr = '0;
			fired_ticks = '0;
			hold_len = '0;
			melody_on = 1'b1;
		end else if (op == tss_pkg::OP_LOAD) begin
			if (int'(addr) < tss_pkg::SCRIPT_DEPTH) begin
				script_img[addr] = data;
			end
		end
		if (events.size() == 0) begin
			events.push_back(melody_on ? IDLE_ON : IDLE_OFF);
		end
		events[events.size()-1].last = 1'b1;
	endtask

	task automatic send_request(input tss_pkg::op_t op, input logic [7:0] addr,
			input logic [7:0] data, input logic typed, input tss_pkg::result_t want);
		tss_pkg::result_t events [$];
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {data, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_request(op, addr, data, events);
		if (typed) begin
			expected_results.push_back(want);
		end else begin
			foreach (events[i]) expected_results.push_back(events[i]);
		end
		if (op != tss_pkg::OP_NONE) begin
			random_reqs++;
		end
	endtask

	task automatic issue(input tss_pkg::op_t op, input logic [7:0] addr, input logic [7:0] data);
		send_request(op, addr, data, 1'b0, IDLE_OFF);
	endtask

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 8'h00;
		end else if (r < 9) begin
			return 8'($urandom_range(1, 3));
		end
		return 8'($urandom_range(4, 255));
	endfunction

	function automatic void add_event(ref logic [7:0] bytes[$], input logic zero_len);
		logic [7:0] semi;
		if ($urandom_range(0, 3) == 0) begin
			bytes.push_back(tss_pkg::EV_STOP);
		end else begin
			semi = tss_pkg::EV_STOP;
			while (semi == tss_pkg::EV_STOP || semi == tss_pkg::EV_END) semi = 8'($urandom);
			bytes.push_back(semi);
			bytes.push_back(8'($urandom));
		end
		bytes.push_back(zero_len ? 8'h00 : pick_length());
	endfunction

	always @(posedge clk) begin
		if (steady) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tss_pkg::result_t got;
		tss_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.command = tss_pkg::cmd_t'(m_axis_tuser);
			got.semitone = m_axis_tdata[7:0];
			got.octave = m_axis_tdata[15:8];
			got.is_playing = m_axis_tdata[16];
			got.last = m_axis_tlast;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending: cmd %0d semi %h oct %h play %b last %b",
					$time, got.command, got.semitone, got.octave, got.is_playing, got.last);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected cmd %0d semi %h oct %h play %b last %b",
						$time, want.command, want.semitone, want.octave,
						want.is_playing, want.last);
					$display("%0t: actual   cmd %0d semi %h oct %h play %b last %b",
						$time, got.command, got.semitone, got.octave,
						got.is_playing, got.last);
				end
			end
		end
	end

	initial begin
		logic [7:0] bytes [$];
		logic burst;
		int round;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data,
				DIRECTED[i].typed, DIRECTED[i].want);
		end
		random_reqs = 0;

		// whole memory loaded so that any pointer walk reads written bytes
		bytes.delete();
		while (bytes.size() < tss_pkg::SCRIPT_DEPTH) add_event(bytes, 1'($urandom_range(0, 1)));
		for (int a = 0; a < tss_pkg::SCRIPT_DEPTH; a++) begin
			issue(tss_pkg::OP_LOAD, 8'(a), bytes[a]);
		end
		issue(tss_pkg::OP_RESTART, 8'($urandom), 8'($urandom));
		repeat (40) issue(tss_pkg::OP_TICK, 8'($urandom), 8'($urandom));

		round = 0;
		while (random_reqs < RANDOM_REQS) begin
			steady <= ($urandom_range(0, 3) == 0) || (random_reqs > RANDOM_REQS * 85 / 100);
			bytes.delete();
			burst = ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(3, burst ? 14 : 8)) add_event(bytes, burst);
			if ($urandom_range(0, 2) != 0) begin
				bytes.push_back(tss_pkg::EV_END);
			end
			foreach (bytes[i]) issue(tss_pkg::OP_LOAD, 8'(i), bytes[i]);
			if (round == 0) begin
				// hold off until the sequencer has drained
				s_axis_tvalid <= 1'b0;
				while (expected_results.size() != 0) @(posedge clk);
			end
			issue(tss_pkg::OP_RESTART, 8'($urandom), 8'($urandom));
			repeat ($urandom_range(12, 48)) begin
				if (random_reqs > RANDOM_REQS * 85 / 100) begin
					steady <= 1'b1;
				end
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					issue(tss_pkg::OP_NONE, 8'($urandom), 8'($urandom));
				end else if (pick == 1) begin
					issue(tss_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
				end else if (pick == 2) begin
					issue(tss_pkg::OP_RESTART, 8'($urandom), 8'($urandom));
				end else begin
					issue(tss_pkg::OP_TICK, 8'($urandom), 8'($urandom));
				end
			end
			round++;
		end

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
